/* hdl/pba_pkg.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Field widths, operation and status codes, register indexes and the
// command and status structures shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int ADDR_W     = 24;
    localparam int FUNC_W     = 1;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 13;
    localparam int FIRST_W    = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int WORD_W     = 64;
    localparam int BIT_W      = 6;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INDEX = 1'b1;

    localparam logic [COUNT_W-1:0] PAGE_COUNT_RESET  = 13'd4096;
    localparam logic [FIRST_W-1:0] FIRST_INDEX_RESET = 12'd1024;

    typedef struct packed {
        logic                accept;
        logic                clr_step;
        logic                scan_step;
        logic                alloc_hit;
        logic                fdiv1;
        logic                fdiv2;
        logic                fdiv3;
        logic                free_rd;
        logic                free_wr;
        logic                st_we;
        logic [STATUS_W-1:0] st;
        logic                load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic start_bad;
        logic chk_valid;
        logic hit;
        logic scan_end;
        logic idx_ok;
        logic slot_free;
    } t_sts;

endpackage

/* hdl/pba_ifs.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pba_req_if;
    logic                         valid;
    logic                         ready;
    logic [pba_pkg::FUNC_W-1:0]   func;
    logic [pba_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output func, output address, input ready);
    modport sink   (input valid, input func, input address, output ready);
endinterface

interface pba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pba_pkg::ADDR_W-1:0]   page_address;
    logic [pba_pkg::STATUS_W-1:0] status;

    modport source (output valid, output page_address, output status, input ready);
    modport sink   (input valid, input page_address, input status, output ready);
endinterface

interface pba_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pba_pkg::CFG_IDX_W-1:0]  index;
    logic [pba_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/pba_controller.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator controller
// Sequences the clearing pass, the allocation scan, the free path and the
// delivery of each result to the output register.
// ----------------------------------------------------------------------------
module pba_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic [pba_pkg::FUNC_W-1:0]    i_func,
    output logic                          o_req_ready,
    input  pba_pkg::t_sts                 i_sts,
    output pba_pkg::t_cmd                 o_cmd
);

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_ALLOC   = 9'b000000100,
        S_FDIV1   = 9'b000001000,
        S_FDIV2   = 9'b000010000,
        S_FDIV3   = 9'b000100000,
        S_FREE_RD = 9'b001000000,
        S_FREE_WR = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_func == pba_pkg::FUNC_FREE) ? S_FDIV1 : S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (i_sts.start_bad) begin
                    o_cmd.st_we = 1'b1;
                    o_cmd.st    = pba_pkg::ST_OOM;
                    n_state     = S_DONE;
                end else if (i_sts.chk_valid && i_sts.hit) begin
                    o_cmd.alloc_hit = 1'b1;
                    o_cmd.st_we     = 1'b1;
                    o_cmd.st        = pba_pkg::ST_OK;
                    n_state         = S_DONE;
                end else if (!i_sts.chk_valid && i_sts.scan_end) begin
                    o_cmd.st_we = 1'b1;
                    o_cmd.st    = pba_pkg::ST_OOM;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_FDIV1: begin
                o_cmd.fdiv1 = 1'b1;
                n_state     = S_FDIV2;
            end
            S_FDIV2: begin
                o_cmd.fdiv2 = 1'b1;
                n_state     = S_FDIV3;
            end
            S_FDIV3: begin
                o_cmd.fdiv3 = 1'b1;
                n_state     = S_FREE_RD;
            end
            S_FREE_RD: begin
                if (i_sts.idx_ok) begin
                    o_cmd.free_rd = 1'b1;
                    n_state       = S_FREE_WR;
                end else begin
                    o_cmd.st_we = 1'b1;
                    o_cmd.st    = pba_pkg::ST_RANGE;
                    n_state     = S_DONE;
                end
            end
            S_FREE_WR: begin
                o_cmd.free_wr = 1'b1;
                o_cmd.st_we   = 1'b1;
                o_cmd.st      = pba_pkg::ST_OK;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

/* hdl/pba_datapath.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator datapath
// Holds the configuration, the page bitmap memory of 64-bit words, the scan
// pointers, the page index divider and the output register.
// ----------------------------------------------------------------------------
module pba_datapath #(
    parameter int NUM_FRAMES = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pba_pkg::t_cmd                     i_cmd,
    output pba_pkg::t_sts                     o_sts,
    input  logic [pba_pkg::FUNC_W-1:0]        i_func,
    input  logic [pba_pkg::ADDR_W-1:0]        i_address,
    input  logic                              i_cfg_we,
    input  logic [pba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pba_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [pba_pkg::ADDR_W-1:0]        o_page_address,
    output logic [pba_pkg::STATUS_W-1:0]      o_status
);

    localparam int WORD_W    = pba_pkg::WORD_W;
    localparam int BIT_W     = pba_pkg::BIT_W;
    localparam int ADDR_W    = pba_pkg::ADDR_W;
    localparam int MAP_WORDS = (NUM_FRAMES + WORD_W - 1) / WORD_W;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int QW        = ADDR_W - $clog2(PAGE_BYTES) + 1;
    localparam int DPW       = ADDR_W + QW;
    localparam int RECIP     = (2 ** ADDR_W) / PAGE_BYTES;
    localparam int PBW       = $clog2(PAGE_BYTES + 1);
    localparam int PRW       = QW + PBW;
    localparam int CNT_W     = $clog2(NUM_FRAMES + 1);
    localparam int CMP_A     = (CNT_W > pba_pkg::COUNT_W) ? CNT_W : pba_pkg::COUNT_W;
    localparam int CMP_W     = (QW > CMP_A) ? QW : CMP_A;
    localparam int WW        = CMP_W - BIT_W;
    localparam int OPW       = (CMP_W + PBW > ADDR_W) ? (CMP_W + PBW) : ADDR_W;

    logic [pba_pkg::COUNT_W-1:0]  r_cfg_count;
    logic [pba_pkg::FIRST_W-1:0]  r_cfg_first;
    logic [pba_pkg::FUNC_W-1:0]   r_func;
    logic [ADDR_W-1:0]            r_addr;
    logic [WORD_W-1:0]            r_map [MAP_WORDS];
    logic [WORD_W-1:0]            r_rdata;
    logic [WA_W-1:0]              r_clr;
    logic [WW-1:0]                r_raddr;
    logic [WW-1:0]                r_chk_word;
    logic                         r_chk_valid;
    logic [QW-1:0]                r_q;
    logic [PRW-1:0]               r_qp;
    logic [CMP_W-1:0]             r_idx;
    logic [pba_pkg::STATUS_W-1:0] r_res_st;
    logic                         r_out_valid;
    logic [ADDR_W-1:0]            r_out_addr;
    logic [pba_pkg::STATUS_W-1:0] r_out_status;

    logic [CMP_W-1:0]  cfg_count_ext;
    logic [CMP_W-1:0]  eff_count;
    logic [CMP_W-1:0]  first_ext;
    logic [CMP_W-1:0]  count_m1;
    logic [WW-1:0]     word_first;
    logic [WW-1:0]     word_last;
    logic              scan_end;
    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_mask;
    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] lowest;
    logic [BIT_W-1:0]  hit_pos;
    logic [DPW-1:0]    div_prod;
    logic [PRW-1:0]    rem;
    logic [OPW-1:0]    out_prod;
    logic [WORD_W-1:0] free_bit;
    logic              mem_we;
    logic [WA_W-1:0]   mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [WA_W-1:0]   mem_raddr;

    assign cfg_count_ext = CMP_W'(r_cfg_count);
    assign eff_count     = (cfg_count_ext > CMP_W'(NUM_FRAMES)) ? CMP_W'(NUM_FRAMES)
                                                                : cfg_count_ext;
    assign first_ext     = CMP_W'(r_cfg_first);
    assign count_m1      = eff_count - CMP_W'(1);
    assign word_first    = first_ext[CMP_W-1:BIT_W];
    assign word_last     = count_m1[CMP_W-1:BIT_W];
    assign scan_end      = (r_raddr > word_last);

    assign lo_mask = (r_chk_word == word_first) ? ({WORD_W{1'b1}} << first_ext[BIT_W-1:0])
                                                : {WORD_W{1'b1}};
    assign hi_mask = (r_chk_word == word_last)
                   ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - count_m1[BIT_W-1:0]))
                   : {WORD_W{1'b1}};
    assign free_bits = ~r_rdata & lo_mask & hi_mask;
    assign lowest    = free_bits & (-free_bits);

    always_comb begin
        hit_pos = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (lowest[b]) begin
                hit_pos = hit_pos | BIT_W'(b);
            end
        end
    end

    assign div_prod = DPW'(r_addr) * DPW'(RECIP);
    assign rem      = PRW'(r_addr) - r_qp;
    assign out_prod = OPW'(r_idx) * OPW'(PAGE_BYTES);
    assign free_bit = WORD_W'(1) << r_idx[BIT_W-1:0];

    assign o_sts.clr_done  = (r_clr == WA_W'(MAP_WORDS - 1));
    assign o_sts.start_bad = (first_ext >= eff_count);
    assign o_sts.chk_valid = r_chk_valid;
    assign o_sts.hit       = |free_bits;
    assign o_sts.scan_end  = scan_end;
    assign o_sts.idx_ok    = (r_idx < eff_count);
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= pba_pkg::PAGE_COUNT_RESET;
            r_cfg_first <= pba_pkg::FIRST_INDEX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pba_pkg::CFG_PAGE_COUNT: begin
                    r_cfg_count <= i_cfg_data[pba_pkg::COUNT_W-1:0];
                end
                pba_pkg::CFG_FIRST_INDEX: begin
                    r_cfg_first <= i_cfg_data[pba_pkg::FIRST_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step && !o_sts.clr_done) begin
                r_clr <= r_clr + WA_W'(1);
            end
            if (i_cmd.accept) begin
                r_chk_valid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_chk_valid <= !scan_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func  <= i_func;
            r_addr  <= i_address;
            r_raddr <= word_first;
        end
        if (i_cmd.scan_step && !scan_end) begin
            r_chk_word <= r_raddr;
            r_raddr    <= r_raddr + WW'(1);
        end
        if (i_cmd.fdiv1) begin
            r_q <= div_prod[ADDR_W +: QW];
        end
        if (i_cmd.fdiv2) begin
            r_qp <= PRW'(r_q) * PRW'(PAGE_BYTES);
        end
        if (i_cmd.fdiv3) begin
            r_idx <= CMP_W'(r_q) + CMP_W'(rem >= PRW'(PAGE_BYTES));
        end
        if (i_cmd.alloc_hit) begin
            r_idx <= {r_chk_word, hit_pos};
        end
        if (i_cmd.st_we) begin
            r_res_st <= i_cmd.st;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = {WORD_W{1'b1}};
        if (i_cmd.alloc_hit) begin
            mem_we    = 1'b1;
            mem_waddr = r_chk_word[WA_W-1:0];
            mem_wdata = r_rdata | lowest;
        end else if (i_cmd.free_wr) begin
            mem_we    = 1'b1;
            mem_waddr = r_idx[BIT_W +: WA_W];
            mem_wdata = r_rdata & ~free_bit;
        end else if (i_cmd.clr_step) begin
            mem_we = 1'b1;
        end
    end

    assign mem_re    = (i_cmd.scan_step && !scan_end) || i_cmd.free_rd;
    assign mem_raddr = i_cmd.free_rd ? r_idx[BIT_W +: WA_W] : r_raddr[WA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_map[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_res_st;
            if ((r_func == pba_pkg::FUNC_ALLOC) && (r_res_st == pba_pkg::ST_OK)) begin
                r_out_addr <= out_prod[ADDR_W-1:0];
            end else begin
                r_out_addr <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_page_address = r_out_addr;
    assign o_status       = r_out_status;

endmodule

/* hdl/page_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator
// First-fit page frame allocator over a used/free bitmap of page frames.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that marks every page used, and
// it accepts no request until the pass is done. An allocate scans the 64-bit
// bitmap words one by one, starting from the word holding first_index, and
// ends at the first word with a free page, or with out of memory past the
// word holding the last page; one whose first_index is at or past the page
// count ends without a scan, with out of memory. The scan is paced by the
// single read port of the bitmap memory, which delivers one word per cycle.
// A free runs a three-step reciprocal division of the address by the page
// size, then a read and a write of one bitmap word; a free beyond the page
// count is refused after the division, with no bitmap access. One request
// is in work at a time, and a finished result waits in the output register
// while the next request is taken.
module page_bitmap_allocator #(
    parameter int NUM_FRAMES = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pba_req_if.sink    i_req,
    pba_rsp_if.source  o_rsp,
    pba_cfg_if.sink    i_cfg
);

    pba_pkg::t_cmd cmd;
    pba_pkg::t_sts sts;

    assign i_cfg.ready = 1'b1;

    pba_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_func      (i_req.func),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pba_datapath #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_req.func),
        .i_address      (i_req.address),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_page_address (o_rsp.page_address),
        .o_status       (o_rsp.status)
    );

endmodule

/* hdl/pba_checker.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
module pba_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_ready,
    input  logic [pba_pkg::ADDR_W-1:0]    i_page_address,
    input  logic [pba_pkg::STATUS_W-1:0]  i_status
);

    // The clearing pass keeps requests out and no result is pending.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready && !i_rsp_valid)
        else $error("request ready or response valid right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request taken while one is in work");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status == pba_pkg::ST_OK) || (i_status == pba_pkg::ST_OOM)
                        || (i_status == pba_pkg::ST_RANGE))
        else $error("undefined status code");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status != pba_pkg::ST_OK) |-> i_page_address == '0)
        else $error("failed request returned a nonzero page address");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_page_address)
                                        && $stable(i_status))
        else $error("stalled response changed");

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_page_address (o_rsp.page_address),
    .i_status       (o_rsp.status)
);

/* tb/page_bitmap_allocator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page bitmap allocator testbench
// Drives allocate and free requests through the request channel and sets
// the page count and scan start through the register channel. A frame map
// model predicts the address and status of every response, which is checked
// in order against the response channel. Random bursts on the request side
// and a changing stall pattern on the response side vary the timing.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_test;

    localparam int          ADDR_W      = pba_pkg::ADDR_W;
    localparam int          STATUS_W    = pba_pkg::STATUS_W;
    localparam int          COUNT_W     = pba_pkg::COUNT_W;
    localparam int          FIRST_W     = pba_pkg::FIRST_W;
    localparam int          FUNC_W      = pba_pkg::FUNC_W;
    localparam int          CFG_IDX_W   = pba_pkg::CFG_IDX_W;
    localparam int          CFG_DATA_W  = pba_pkg::CFG_DATA_W;
    localparam int          PAGE_LIMIT  = 4096;
    localparam int unsigned FRAME_BYTES = 4096;
    localparam int          PHASES      = 10;
    localparam int          PHASE_REQS  = 175;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} t_rx_mode;

    class t_scoreboard;
        typedef struct packed {
            logic [ADDR_W-1:0]   page_address;
            logic [STATUS_W-1:0] status;
        } t_frame_result;

        bit                 page_in_use[PAGE_LIMIT];
        logic [COUNT_W-1:0] page_count;
        logic [FIRST_W-1:0] first_index;
        t_frame_result      pending_results[$];
        int                 errors, checked, grants, exhausted, frees, refused;

        function new();
            foreach (page_in_use[i]) page_in_use[i] = 1'b1;
            page_count  = pba_pkg::PAGE_COUNT_RESET;
            first_index = pba_pkg::FIRST_INDEX_RESET;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == pba_pkg::CFG_PAGE_COUNT) begin
                page_count = data[COUNT_W-1:0];
            end else if (index == pba_pkg::CFG_FIRST_INDEX) begin
                first_index = data[FIRST_W-1:0];
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] address);
            t_frame_result r;
            int unsigned   limit;
            int unsigned   idx;
            limit = (page_count > PAGE_LIMIT) ? PAGE_LIMIT : page_count;
            r.page_address = '0;
            r.status       = pba_pkg::ST_OK;
            if (func == pba_pkg::FUNC_ALLOC) begin
                idx = first_index;
                while (idx < limit && page_in_use[idx]) idx++;
                if (idx < limit) begin
                    page_in_use[idx] = 1'b1;
                    r.page_address   = ADDR_W'(idx * FRAME_BYTES);
                    grants++;
                end else begin
                    r.status = pba_pkg::ST_OOM;
                    exhausted++;
                end
            end else begin
                idx = address / FRAME_BYTES;
                if (idx < limit) begin
                    page_in_use[idx] = 1'b0;
                    frees++;
                end else begin
                    r.status = pba_pkg::ST_RANGE;
                    refused++;
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [ADDR_W-1:0] page_address,
                                   logic [STATUS_W-1:0] status);
            t_frame_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: response with nothing outstanding: address %h status %0d",
                         $time, page_address, status);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (page_address !== want.page_address) begin
                $display("%0t: page_address mismatch: expected %h actual %h",
                         $time, want.page_address, page_address);
                errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pba_req_if req_ch();
    pba_rsp_if rsp_ch();
    pba_cfg_if cfg_ch();

    t_scoreboard board = new();

    int       burst_left;
    bit       steady_send;
    int       settings;
    t_rx_mode stall_mode;
    logic [7:0] stall_pattern;
    int unsigned stall_cycle;

    page_bitmap_allocator #(
        .NUM_FRAMES (PAGE_LIMIT),
        .PAGE_BYTES (FRAME_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        stall_cycle++;
        if (stall_cycle % 300 == 0) begin
            stall_mode    = t_rx_mode'($urandom_range(0, 3));
            stall_pattern = 8'($urandom()) | 8'h01;
        end
        case (stall_mode)
            RX_ALWAYS:  rsp_ch.ready <= 1'b1;
            RX_RANDOM:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: rsp_ch.ready <= stall_pattern[stall_cycle[2:0]];
            default:    rsp_ch.ready <= (stall_cycle % 9 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) board.apply_reg(cfg_ch.index, cfg_ch.data);
            if (rsp_ch.valid && rsp_ch.ready) begin
                board.check_result(rsp_ch.page_address, rsp_ch.status);
            end
            if (req_ch.valid && req_ch.ready) board.note_request(req_ch.func, req_ch.address);
        end
    end

    task automatic issue(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] address);
        if (burst_left == 0) begin
            if (!steady_send) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        req_ch.valid   <= 1'b1;
        req_ch.func    <= func;
        req_ch.address <= address;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (board.pending() != 0);
    endtask

    task automatic program_regs(logic [CFG_DATA_W-1:0] count, logic [FIRST_W-1:0] first);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= pba_pkg::CFG_PAGE_COUNT;
        cfg_ch.data  <= count;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.index <= pba_pkg::CFG_FIRST_INDEX;
        cfg_ch.data  <= CFG_DATA_W'(first);
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        settings++;
    endtask

    function automatic logic [ADDR_W-1:0] frame_address(int unsigned idx);
        return {idx[11:0], 12'($urandom())};
    endfunction

    function automatic logic [ADDR_W-1:0] any_address();
        return ADDR_W'($urandom_range(0, 24'hFFFFFF));
    endfunction

    initial begin
        int unsigned count;
        int unsigned eff;
        int unsigned first;
        int unsigned alloc_pct;
        int unsigned pick;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.func    = pba_pkg::FUNC_ALLOC;
        req_ch.address = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = pba_pkg::CFG_PAGE_COUNT;
        cfg_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        stall_mode     = RX_ALWAYS;
        stall_pattern  = 8'hFF;
        stall_cycle    = 0;
        burst_left     = 0;
        steady_send    = 1'b0;
        settings       = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(pba_pkg::FUNC_ALLOC, 24'h000000);
        issue(pba_pkg::FUNC_FREE, 24'h000000);
        issue(pba_pkg::FUNC_FREE, 24'hFFFFFF);
        issue(pba_pkg::FUNC_FREE, 24'h400ABC);
        issue(pba_pkg::FUNC_ALLOC, 24'hFFFFFF);
        issue(pba_pkg::FUNC_ALLOC, 24'h123456);
        issue(pba_pkg::FUNC_ALLOC, 24'h000000);
        issue(pba_pkg::FUNC_FREE, 24'h401000);
        issue(pba_pkg::FUNC_FREE, 24'h401FFF);
        issue(pba_pkg::FUNC_ALLOC, 24'hABCDEF);
        drain();
        program_regs(13'd100, 12'd0);
        issue(pba_pkg::FUNC_ALLOC, 24'h000000);
        issue(pba_pkg::FUNC_FREE, 24'h064000);
        issue(pba_pkg::FUNC_FREE, 24'hFFFFFF);
        issue(pba_pkg::FUNC_FREE, 24'h063FFF);
        issue(pba_pkg::FUNC_ALLOC, 24'h000000);
        issue(pba_pkg::FUNC_FREE, 24'h032000);
        drain();
        program_regs(13'd100, 12'd100);
        issue(pba_pkg::FUNC_ALLOC, 24'h000000);
        drain();
        program_regs(13'd100, 12'd4095);
        issue(pba_pkg::FUNC_ALLOC, 24'h000000);
        drain();
        program_regs(13'd8191, 12'd4095);
        issue(pba_pkg::FUNC_FREE, 24'hFFF000);
        issue(pba_pkg::FUNC_ALLOC, 24'h000000);
        drain();
        program_regs(13'd0, 12'd0);
        issue(pba_pkg::FUNC_ALLOC, 24'h000000);
        issue(pba_pkg::FUNC_FREE, 24'h000000);
        drain();
        program_regs(13'd4096, 12'd0);
        issue(pba_pkg::FUNC_ALLOC, 24'h000000);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 9))
                0:       count = 4096;
                1:       count = $urandom_range(4097, 8191);
                2:       count = $urandom_range(1, 64);
                default: count = $urandom_range(1, 4096);
            endcase
            eff = (count > PAGE_LIMIT) ? PAGE_LIMIT : count;
            case ($urandom_range(0, 7))
                0:       first = 0;
                1:       first = 4095;
                default: first = $urandom_range(0, eff - 1) / $urandom_range(1, 4);
            endcase
            program_regs(CFG_DATA_W'(count), FIRST_W'(first));
            steady_send = (phase % 4 == 1);
            alloc_pct   = $urandom_range(30, 70);
            for (int n = 0; n < PHASE_REQS; n++) begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(1, 100) <= alloc_pct) begin
                    issue(pba_pkg::FUNC_ALLOC, any_address());
                end else if (pick < 60 && first < eff) begin
                    issue(pba_pkg::FUNC_FREE, frame_address($urandom_range(first, eff - 1)));
                end else if (pick < 85) begin
                    issue(pba_pkg::FUNC_FREE, frame_address($urandom_range(0, eff - 1)));
                end else begin
                    issue(pba_pkg::FUNC_FREE, any_address());
                end
                if ($urandom_range(0, 99) == 0) drain();
            end
            drain();
        end

        repeat (80) @(negedge i_clk);
        $display("Checked %0d responses over %0d register settings: %0d grants,",
                 board.checked, settings, board.grants);
        $display("%0d out of memory, %0d frees accepted, %0d frees refused as out of range.",
                 board.exhausted, board.frees, board.refused);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("Run timed out with %0d responses outstanding.", board.pending());
        $display("TEST FAILED");
        $finish;
    end

endmodule
